@@ rtl/rect_pkg.sv @@
// Shared types and constants for the radio event collision table.
`timescale 1ns / 1ps

package rect_pkg;

	// Request selector codes.
	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HALF_BAND   = 2'd0;
	localparam logic [1:0] CFG_AGE_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_PURGE_LEVEL = 2'd2;

	localparam logic [15:0] RST_HALF_BAND   = 16'd50;
	localparam logic [31:0] RST_AGE_LIMIT   = 32'd2000000;
	localparam logic [7:0]  RST_PURGE_LEVEL = 8'd100;

	typedef struct packed {
		func_t       func;
		logic [47:0] now;
		logic [31:0] duration;
		logic [31:0] frequency;
		logic [6:0]  slot;
	} req_t;

	typedef struct packed {
		logic [6:0] slot_out;
		logic       accepted;
		logic       destroyed;
	} res_t;

	typedef struct packed {
		logic [15:0] half_band;
		logic [31:0] age_limit;
		logic [7:0]  purge_level;
	} cfg_t;

	// Kind of pass walking the cell row; NONE marks an empty chain slot.
	typedef enum logic [2:0] {
		PASS_NONE  = 3'd0,
		PASS_ADD   = 3'd1,
		PASS_PURGE = 3'd2,
		PASS_FIND  = 3'd3,
		PASS_CMP   = 3'd4
	} pass_op_t;

	// Packet handed from cell to cell.
	// ADD:   t_start/t_stop/freq/t_len are the new entry, found = placed.
	// PURGE: t_start is the current time.
	// FIND/CMP: t_* describe the target entry once found.
	typedef struct packed {
		pass_op_t    op;
		logic [47:0] t_start;
		logic [47:0] t_stop;
		logic [31:0] freq;
		logic [6:0]  slot;
		logic        t_len;
		logic        found;
		logic        hit;
	} pkt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_PURGE,
		ST_FIND,
		ST_CMP
	} ctrl_state_t;

endpackage

@@ rtl/radio_event_collision_table_unit.sv @@
// Top level of the radio event collision table: sequencer plus a row of entry cells.
`timescale 1ns / 1ps

// Usage
//  - Request channel: drive req and raise start; the transaction is taken on a
//    rising edge with start high and busy low. func selects add, query, clear
//    or no operation.
//  - Result channel: done pulses for one cycle with result valid alongside.
//    The receiver cannot stall; a result not sampled in that cycle is gone.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Writes
//    complete only while no request is in flight (cfg_ready is low when busy).
//  - Each table entry lives in its own cell. A pass packet enters cell 0 and
//    moves one cell per clock until the last cell hands it back to the sequencer.
//  - Walks per request: add walks the row once, and again for the age purge
//    when it triggers one; query walks once when the slot is empty or a later
//    entry collides, else a compare walk follows; clear and no-op answer without a walk.
//  - An add or query keeps busy high until its done (busy drops in the cycle
//    done is shown); clear and no-op go back to back.
//  - Reset: all entries invalid, count zero, config registers at defaults
//    (half band 50 Hz, age limit 2 s, purge level 100). Entry payloads are
//    not cleared; a valid bit per cell guards them.

module radio_event_collision_table_unit #(
	parameter int DEPTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rect_pkg::req_t   req,
	output logic             done,
	output rect_pkg::res_t   result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import rect_pkg::*;

	localparam int IW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH+1);

	cfg_t            cfg;
	logic            clr;
	pkt_t            pkt_chain [DEPTH+1];
	logic [IW-1:0]   idx_chain [DEPTH+1];
	logic [CNTW-1:0] cnt_chain [DEPTH+1];

	rect_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.launch    (pkt_chain[0]),
		.clr       (clr),
		.tail      (pkt_chain[DEPTH]),
		.tail_idx  (idx_chain[DEPTH]),
		.tail_cnt  (cnt_chain[DEPTH])
	);

	// slot index and surviving-entry count ride along with the packet from zero
	assign idx_chain[0] = '0;
	assign cnt_chain[0] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		rect_cell #(
			.DEPTH (DEPTH),
			.INDEX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg),
			.clr     (clr),
			.pkt_in  (pkt_chain[g]),
			.idx_in  (idx_chain[g]),
			.cnt_in  (cnt_chain[g]),
			.pkt_out (pkt_chain[g+1]),
			.idx_out (idx_chain[g+1]),
			.cnt_out (cnt_chain[g+1])
		);
	end

endmodule

@@ rtl/rect_cell.sv @@
// One table entry with its local add, purge and overlap logic.
`timescale 1ns / 1ps

module rect_cell #(
	parameter int DEPTH = 128,
	parameter int INDEX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rect_pkg::cfg_t               cfg,
	input  logic                         clr,
	input  rect_pkg::pkt_t               pkt_in,
	input  logic [$clog2(DEPTH)-1:0]     idx_in,
	input  logic [$clog2(DEPTH+1)-1:0]   cnt_in,
	output rect_pkg::pkt_t               pkt_out,
	output logic [$clog2(DEPTH)-1:0]     idx_out,
	output logic [$clog2(DEPTH+1)-1:0]   cnt_out
);
	import rect_pkg::*;

	localparam int IW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH+1);
	localparam int CW   = (IW > 7) ? IW : 7;
	localparam logic [IW-1:0] MY_IDX  = IW'(INDEX);
	localparam logic [CW-1:0] MY_SLOT = CW'(INDEX);

	logic        valid_q;
	logic [47:0] start_q;
	logic [47:0] end_q;
	logic [31:0] freq_q;
	logic        len_q;

	pkt_t               pkt_d;
	logic [IW-1:0]      idx_d;
	logic [CNTW-1:0]    cnt_d;
	logic               wr;
	logic               erase;
	logic               match;
	logic               aged;
	logic               ovl;
	logic [16:0]        band2;

	assign band2 = {cfg.half_band, 1'b0};
	assign match = (MY_SLOT == CW'(pkt_in.slot));
	assign aged  = ({1'b0, end_q} + {17'b0, cfg.age_limit}) < {1'b0, pkt_in.t_start};

	// strict time overlap on both sides, frequency gap under twice the half band
	assign ovl = valid_q & len_q & pkt_in.t_len
		& (end_q > pkt_in.t_start) & (pkt_in.t_stop > start_q)
		& ({2'b0, freq_q} < ({2'b0, pkt_in.freq} + {17'b0, band2}))
		& ({2'b0, pkt_in.freq} < ({2'b0, freq_q} + {17'b0, band2}));

	always_comb begin
		pkt_d = pkt_in;
		idx_d = idx_in;
		cnt_d = cnt_in;
		wr    = 1'b0;
		erase = 1'b0;
		case (pkt_in.op)
			PASS_ADD: begin
				if (!pkt_in.found && !valid_q) begin
					wr          = 1'b1;
					pkt_d.found = 1'b1;
					idx_d       = MY_IDX;
				end
			end
			PASS_PURGE: begin
				erase = valid_q & aged;
				cnt_d = cnt_in + CNTW'(valid_q & ~aged);
			end
			PASS_FIND: begin
				if (!pkt_in.found) begin
					if (match && valid_q) begin
						pkt_d.t_start = start_q;
						pkt_d.t_stop  = end_q;
						pkt_d.freq    = freq_q;
						pkt_d.t_len   = len_q;
						pkt_d.found   = 1'b1;
					end
				end else if (ovl) begin
					pkt_d.hit = 1'b1;
				end
			end
			PASS_CMP: begin
				if (!match && ovl) begin
					pkt_d.hit = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pkt_out <= '0;
		end else begin
			pkt_out <= pkt_d;
			if (clr || erase) begin
				valid_q <= 1'b0;
			end else if (wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_out <= idx_d;
		cnt_out <= cnt_d;
		if (wr) begin
			start_q <= pkt_in.t_start;
			end_q   <= pkt_in.t_stop;
			freq_q  <= pkt_in.freq;
			len_q   <= pkt_in.t_len;
		end
	end

endmodule

@@ rtl/rect_ctrl.sv @@
// Sequencer: launches passes into the cell row, tracks count, holds config.
`timescale 1ns / 1ps

module rect_ctrl #(
	parameter int DEPTH = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  rect_pkg::req_t               req,
	output logic                         done,
	output rect_pkg::res_t               result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	output rect_pkg::cfg_t               cfg,
	output rect_pkg::pkt_t               launch,
	output logic                         clr,
	input  rect_pkg::pkt_t               tail,
	input  logic [$clog2(DEPTH)-1:0]     tail_idx,
	input  logic [$clog2(DEPTH+1)-1:0]   tail_cnt
);
	import rect_pkg::*;

	localparam int CNTW = $clog2(DEPTH+1);
	localparam int LW   = (CNTW > 8) ? CNTW : 8;

	ctrl_state_t     state_q, state_d;
	pkt_t            launch_q, launch_d;
	res_t            res_q, res_d;
	logic            done_q, done_d;
	logic            clr_q, clr_d;
	logic [CNTW-1:0] count_q, count_d;
	cfg_t            cfg_q;

	logic            tail_vld;
	logic            accept;
	logic [48:0]     stop_sum;
	logic [47:0]     stop_sat;
	logic [CNTW-1:0] cnt_inc;
	logic            add_purge;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign cfg_ready = ~busy;
	assign tail_vld  = (tail.op != PASS_NONE);
	assign stop_sum  = {1'b0, req.now} + {17'b0, req.duration};
	assign stop_sat  = stop_sum[48] ? {48{1'b1}} : stop_sum[47:0];
	assign cnt_inc   = count_q + CNTW'(1);
	assign add_purge = LW'(cnt_inc) > LW'(cfg_q.purge_level);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.func)
						FUNC_ADD:   state_d = ST_ADD;
						FUNC_QUERY: state_d = ST_FIND;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (tail_vld) begin
					state_d = (tail.found && add_purge) ? ST_PURGE : ST_IDLE;
				end
			end
			ST_PURGE: begin
				if (tail_vld) state_d = ST_IDLE;
			end
			ST_FIND: begin
				if (tail_vld) begin
					state_d = (tail.found && !tail.hit) ? ST_CMP : ST_IDLE;
				end
			end
			ST_CMP: begin
				if (tail_vld) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		launch_d = '0;
		res_d    = res_q;
		done_d   = 1'b0;
		clr_d    = 1'b0;
		count_d  = count_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.func)
						FUNC_ADD: begin
							launch_d.op      = PASS_ADD;
							launch_d.t_start = req.now;
							launch_d.t_stop  = stop_sat;
							launch_d.freq    = req.frequency;
							launch_d.t_len   = (stop_sat > req.now);
						end
						FUNC_QUERY: begin
							launch_d.op   = PASS_FIND;
							launch_d.slot = req.slot;
						end
						FUNC_CLEAR: begin
							clr_d   = 1'b1;
							count_d = '0;
							res_d   = '0;
							done_d  = 1'b1;
						end
						default: begin
							res_d  = '0;
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_ADD: begin
				if (tail_vld) begin
					res_d = '0;
					if (tail.found) begin
						count_d        = cnt_inc;
						res_d.slot_out = 7'(tail_idx);
						res_d.accepted = 1'b1;
						if (add_purge) begin
							launch_d.op      = PASS_PURGE;
							launch_d.t_start = tail.t_start;
						end else begin
							done_d = 1'b1;
						end
					end else begin
						done_d = 1'b1;
					end
				end
			end
			ST_PURGE: begin
				if (tail_vld) begin
					count_d = tail_cnt;
					done_d  = 1'b1;
				end
			end
			ST_FIND: begin
				if (tail_vld) begin
					res_d = '0;
					if (tail.found && !tail.hit) begin
						launch_d     = tail;
						launch_d.op  = PASS_CMP;
						launch_d.hit = 1'b0;
					end else begin
						res_d.destroyed = tail.hit;
						done_d          = 1'b1;
					end
				end
			end
			ST_CMP: begin
				if (tail_vld) begin
					res_d           = '0;
					res_d.destroyed = tail.hit;
					done_d          = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= '0;
			done_q   <= 1'b0;
			clr_q    <= 1'b0;
			count_q  <= '0;
			res_q    <= '0;
			cfg_q.half_band   <= RST_HALF_BAND;
			cfg_q.age_limit   <= RST_AGE_LIMIT;
			cfg_q.purge_level <= RST_PURGE_LEVEL;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			done_q   <= done_d;
			clr_q    <= clr_d;
			count_q  <= count_d;
			res_q    <= res_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HALF_BAND:   cfg_q.half_band   <= cfg_data[15:0];
					CFG_AGE_LIMIT:   cfg_q.age_limit   <= cfg_data;
					CFG_PURGE_LEVEL: cfg_q.purge_level <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	assign launch = launch_q;
	assign clr    = clr_q;
	assign done   = done_q;
	assign result = res_q;
	assign cfg    = cfg_q;

endmodule

@@ verif/radio_event_collision_table_unit_test.sv @@
// Self-checking testbench for the radio event collision table unit.
`timescale 1ns / 1ps

module radio_event_collision_table_unit_test;
	import rect_pkg::*;

	localparam int DEPTH        = 128;
	// Slowest transaction, accept to done: add with purge, or a query on a live slot with no later hit.
	localparam int WALK         = 2 * DEPTH + 2;
	// Cycles with no transaction on any channel before the run is declared hung.
	localparam int STALL_LIMIT  = 4000;
	// Index with no register behind it; a write there must change nothing.
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [47:0] TIME_MAX = '1;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	res_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	radio_event_collision_table_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Shadow copy of the event table and of the register file.
	bit          ev_live  [DEPTH];
	logic [47:0] ev_open  [DEPTH];
	logic [47:0] ev_close [DEPTH];
	logic [31:0] ev_freq  [DEPTH];
	int          live_count;
	logic [15:0] band_half;
	logic [31:0] age_max;
	logic [7:0]  purge_above;

	// Results owed by the block, oldest first.
	res_t        owed_results[$];

	int          errors       = 0;
	int          n_items      = 0;
	int          n_results    = 0;
	int          n_refused    = 0;
	int          n_hits       = 0;
	int          n_purges     = 0;
	int          quiet_cycles = 0;
	bit          gaps_on;

	// Traffic shape for random items: a running clock and a few nearby carriers.
	logic [47:0] epoch;
	logic [31:0] carrier [4];

	// Applies one request to the shadow table and returns what the block must answer.
	function automatic res_t table_apply(req_t r);
		res_t        res;
		int          free_slot;
		logic [48:0] stop;
		logic [47:0] lo_end;
		logic [47:0] hi_start;
		logic [32:0] gap;
		res = '0;
		case (r.func)
			FUNC_ADD: begin
				free_slot = -1;
				for (int i = DEPTH - 1; i >= 0; i--)
					if (!ev_live[i])
						free_slot = i;
				if (free_slot >= 0) begin
					// end time clamps at the top of the 48-bit range
					stop = {1'b0, r.now} + {17'd0, r.duration};
					ev_live[free_slot]  = 1'b1;
					ev_open[free_slot]  = r.now;
					ev_close[free_slot] = stop[48] ? TIME_MAX : stop[47:0];
					ev_freq[free_slot]  = r.frequency;
					live_count++;
					if (live_count > purge_above) begin
						n_purges++;
						for (int i = 0; i < DEPTH; i++) begin
							if (ev_live[i] &&
								({1'b0, ev_close[i]} + {17'd0, age_max}) < {1'b0, r.now}) begin
								ev_live[i] = 1'b0;
								live_count--;
							end
						end
					end
					res.slot_out = free_slot[6:0];
					res.accepted = 1'b1;
				end else begin
					n_refused++;
				end
			end
			FUNC_QUERY: begin
				if (ev_live[r.slot]) begin
					for (int i = 0; i < DEPTH; i++) begin
						if (i != r.slot && ev_live[i]) begin
							lo_end   = (ev_close[i] < ev_close[r.slot]) ? ev_close[i] : ev_close[r.slot];
							hi_start = (ev_open[i] > ev_open[r.slot]) ? ev_open[i] : ev_open[r.slot];
							gap      = (ev_freq[i] > ev_freq[r.slot]) ? ev_freq[i] - ev_freq[r.slot]
								: ev_freq[r.slot] - ev_freq[i];
							// strict overlap in time, strictly inside the full band
							if (lo_end > hi_start && gap < {16'd0, band_half, 1'b0})
								res.destroyed = 1'b1;
						end
					end
				end
				n_hits += res.destroyed;
			end
			FUNC_CLEAR: begin
				foreach (ev_live[i])
					ev_live[i] = 1'b0;
				live_count = 0;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic req_t radio_req(func_t f, logic [47:0] now, logic [31:0] dur,
		logic [31:0] freq, logic [6:0] slot);
		req_t r;
		r.func      = f;
		r.now       = now;
		r.duration  = dur;
		r.frequency = freq;
		r.slot      = slot;
		return r;
	endfunction

	function automatic void pick_band_plan(bit near_top);
		logic [31:0] base;
		epoch = near_top ? TIME_MAX - 48'($urandom_range(0, 20000)) : {16'($urandom), $urandom};
		base  = $urandom;
		foreach (carrier[k])
			carrier[k] = base + 32'(k * 300);
	endfunction

	// Mostly well-formed radio traffic: short bursts on shared carriers, queries
	// aimed at live slots. About one item in ten is raw noise over full ranges.
	function automatic req_t radio_item();
		req_t r;
		int   roll;
		int   live_slots[$];
		roll        = $urandom_range(99);
		epoch      += 48'($urandom_range(0, 150));
		r.func      = FUNC_ADD;
		r.now       = epoch;
		r.duration  = $urandom_range(0, 400);
		r.frequency = carrier[$urandom_range(3)] + $urandom_range(0, 250);
		r.slot      = 7'($urandom_range(DEPTH - 1));
		if (roll < 55) begin
			r.func = FUNC_ADD;
		end else if (roll < 85) begin
			r.func = FUNC_QUERY;
			foreach (ev_live[i])
				if (ev_live[i])
					live_slots = {live_slots, i};
			if (live_slots.size() != 0 && $urandom_range(9) < 8)
				r.slot = 7'(live_slots[$urandom_range(live_slots.size() - 1)]);
		end else if (roll < 88) begin
			r.func = FUNC_CLEAR;
		end else if (roll < 90) begin
			r.func = FUNC_NOP;
		end else begin
			r.func      = func_t'($urandom_range(3));
			r.now       = {16'($urandom), $urandom};
			r.duration  = $urandom;
			r.frequency = $urandom;
		end
		return r;
	endfunction

	// Sends one request transaction. start may drop for a cycle at random while
	// waiting, so the accept edge lands at varying points after busy falls.
	// start is left high on return; the next caller drives it at the next falling edge.
	task automatic issue(input req_t item);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (gaps_on && $urandom_range(99) < 18) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req   <= item;
			end
			@(posedge clk);
			taken = start && !busy;
		end
		owed_results.insert(owed_results.size(), table_apply(item));
		n_items++;
	endtask

	// Sender holds off until every owed result has come back.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			CFG_HALF_BAND:   band_half   = data[15:0];
			CFG_AGE_LIMIT:   age_max     = data;
			CFG_PURGE_LEVEL: purge_above = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [31:0] half, input logic [31:0] age,
		input logic [31:0] level);
		settle();
		write_reg(CFG_HALF_BAND, half);
		write_reg(CFG_AGE_LIMIT, age);
		write_reg(CFG_PURGE_LEVEL, level);
	endtask

	// Reset settings: full band 100 Hz, so gaps of 99 collide and 100 do not.
	task automatic test_overlap_rules();
		issue(radio_req(FUNC_NOP, TIME_MAX, '1, '1, 7'h7F));
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd0));          // empty table
		issue(radio_req(FUNC_ADD, 48'd0, 32'd0, 32'd0, 7'd0));            // zero length, slot 0
		issue(radio_req(FUNC_ADD, 48'd0, 32'd100, 32'd0, 7'd0));          // slot 1
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd0));          // zero length never hits
		issue(radio_req(FUNC_ADD, 48'd50, 32'd100, 32'd99, 7'd0));        // slot 2
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd2));          // gap 99 vs slot 1
		issue(radio_req(FUNC_ADD, 48'd50, 32'd100, 32'd199, 7'd0));       // slot 3
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd3));          // gap exactly 100
		issue(radio_req(FUNC_ADD, 48'd150, 32'd10, 32'd0, 7'd0));         // slot 4, touches ends
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd4));
		issue(radio_req(FUNC_ADD, TIME_MAX - 48'd10, '1, 32'd12345, 7'd0));   // end clamps
		issue(radio_req(FUNC_ADD, TIME_MAX - 48'd5, 32'd1, 32'd12444, 7'd0));
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd6));
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd127));        // never written
		issue(radio_req(FUNC_ADD, TIME_MAX, '1, '1, 7'h7F));
		issue(radio_req(FUNC_CLEAR, TIME_MAX, '1, '1, 7'h7F));
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd0));
		issue(radio_req(FUNC_NOP, 48'd0, 32'd0, 32'd0, 7'd0));
	endtask

	task automatic test_purge_and_band_limits();
		// purge level zero: every stored add runs a pass; zero age frees anything ended
		apply_settings(32'd50, 32'd0, 32'd0);
		issue(radio_req(FUNC_ADD, 48'd10, 32'd0, 32'd0, 7'd0));
		issue(radio_req(FUNC_ADD, 48'd20, 32'd5, 32'd0, 7'd0));           // frees slot 0
		issue(radio_req(FUNC_ADD, 48'd20, 32'd5, 32'd0, 7'd0));           // reuses slot 0
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd0));
		// zero band: even identical carriers do not collide
		apply_settings(32'd0, 32'd0, 32'd0);
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd0));
		apply_settings(32'hFFFF, 32'hFFFF_FFFF, 32'hFF);
		write_reg(CFG_SPARE, $urandom);
		issue(radio_req(FUNC_ADD, 48'd21, 32'd1, 32'd131069, 7'd0));      // one under full band
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd2));
		issue(radio_req(FUNC_CLEAR, 48'd0, 32'd0, 32'd0, 7'd0));
	endtask

	// Fill every slot with purging out of reach, then knock on the full table.
	task automatic test_full_table();
		req_t r;
		apply_settings(32'd120, RST_AGE_LIMIT, 32'd128);
		pick_band_plan(1'b0);
		issue(radio_req(FUNC_CLEAR, 48'd0, 32'd0, 32'd0, 7'd0));
		repeat (DEPTH) begin
			r      = radio_item();
			r.func = FUNC_ADD;
			issue(r);
		end
		issue(radio_req(FUNC_ADD, epoch, 32'd10, carrier[0], 7'd0));
		issue(radio_req(FUNC_ADD, TIME_MAX, '1, '1, 7'h7F));
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd127));
		issue(radio_req(FUNC_QUERY, 48'd0, 32'd0, 32'd0, 7'd0));
		repeat (6) begin
			r      = radio_item();
			r.func = FUNC_QUERY;
			issue(r);
		end
		issue(radio_req(FUNC_CLEAR, 48'd0, 32'd0, 32'd0, 7'd0));
	endtask

	// Ten phases of random traffic; each phase first writes a register setting, drawn from five kinds in turn.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 10; phase++) begin
			case (phase % 5)
				0: apply_settings($urandom_range(1, 200), $urandom_range(100, 3000),
					$urandom_range(1, 20));
				1: apply_settings(32'd0, 32'd0, 32'd0);
				2: apply_settings(32'hFFFF, 32'hFFFF_FFFF, 32'hFF);
				3: apply_settings($urandom, $urandom, $urandom);
				default: apply_settings($urandom_range(1, 100), RST_AGE_LIMIT, RST_PURGE_LEVEL);
			endcase
			pick_band_plan(phase == 7);
			gaps_on = (phase != 4);   // phase 4 runs with start never dropped
			for (int k = 0; k < 70; k++) begin
				issue(radio_item());
				if (k == 35 && phase % 3 == 0)
					settle();
			end
		end
		gaps_on = 1'b1;
	endtask

	// Result checker: each done pulse must match the oldest owed result.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			n_results <= n_results + 1;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result slot_out %0d accepted %0b destroyed %0b",
					$time, result.slot_out, result.accepted, result.destroyed);
			end else begin
				want = owed_results.pop_front();
				if (result.slot_out !== want.slot_out) begin
					errors++;
					$display("%0t: slot_out expected %0d, got %0d",
						$time, want.slot_out, result.slot_out);
				end
				if (result.accepted !== want.accepted) begin
					errors++;
					$display("%0t: accepted expected %0b, got %0b",
						$time, want.accepted, result.accepted);
				end
				if (result.destroyed !== want.destroyed) begin
					errors++;
					$display("%0t: destroyed expected %0b, got %0b",
						$time, want.destroyed, result.destroyed);
				end
			end
		end
	end

	// Watchdog: any request, result or register transaction restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		start       = 1'b0;
		req         = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_HALF_BAND;
		cfg_data    = '0;
		arst_n      = 1'b0;
		gaps_on     = 1'b1;
		band_half   = RST_HALF_BAND;
		age_max     = RST_AGE_LIMIT;
		purge_above = RST_PURGE_LEVEL;
		live_count  = 0;
		foreach (ev_live[i])
			ev_live[i] = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_overlap_rules();
		test_purge_and_band_limits();
		test_full_table();
		test_random_traffic();

		settle();
		repeat (WALK) @(posedge clk);
		if (owed_results.size() != 0) begin
			errors += owed_results.size();
			$display("%0t: %0d results never arrived", $time, owed_results.size());
		end
		$display("Run covered %0d requests and %0d results under many register settings,",
			n_items, n_results);
		$display("with %0d collisions flagged, %0d adds refused on a full table, %0d purge passes.",
			n_hits, n_refused, n_purges);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ radio_event_collision_table_unit.f @@
rtl/rect_pkg.sv
rtl/rect_cell.sv
rtl/rect_ctrl.sv
rtl/radio_event_collision_table_unit.sv
verif/radio_event_collision_table_unit_test.sv
